// ===== hw/rtl/binary_to_decimal_ascii_top_macros.svh =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_macros
// assertion macros for the binary to decimal ascii converter
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold whenever its antecedent is seen
`define B2DA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("b2da assertion failed");

// condition in one cycle implies a condition in the next
`define B2DA_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("b2da assertion failed");

`else

`define B2DA_ASSERT(lbl, prop)
`define B2DA_ASSERT_NEXT(lbl, cond, nxt)

`endif

`endif

// ===== hw/rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// shared constants of the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int B2DA_VALUE_BITS = 32;
    localparam int B2DA_DIGIT_W    = 4;
    localparam int B2DA_ASCII_W    = 6;

    localparam logic [B2DA_ASCII_W-1:0] B2DA_ASCII_ZERO = 6'd48;

endpackage

// ===== hw/rtl/binary_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// a shift-add-3 (double-dabble) conversion runs over the VALUE_BITS input bits,
// then the digit positions are scanned one per cycle, most significant first;
// digits are strobed from the first nonzero one, or only the last if all are zero.
// synchronous active-low reset returns to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_top_macros.svh"

module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = B2DA_VALUE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [VALUE_BITS-1:0]   i_value,
    output logic                    o_strobe,
    output logic [B2DA_ASCII_W-1:0] o_ascii_digit,
    output logic                    o_last_digit
);

    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W      = NUM_DIGITS * B2DA_DIGIT_W;
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]              r_state,   n_state;
    logic [VALUE_BITS-1:0]   r_bin,     n_bin;
    logic [BCD_W-1:0]        r_bcd,     n_bcd;
    logic [BIT_CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [DIG_CNT_W-1:0]    r_dig_cnt, n_dig_cnt;
    logic                    r_seen,    n_seen;
    logic                    r_strobe,  n_strobe;
    logic [B2DA_ASCII_W-1:0] r_ascii,   n_ascii;
    logic                    r_last,    n_last;

    logic [BCD_W-1:0]        w_adj;
    logic [B2DA_DIGIT_W-1:0] w_top;
    logic                    w_emit;
    logic                    w_final;

    // add 3 to every digit of 5 or more before the shift
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_adj
        assign w_adj[g*B2DA_DIGIT_W +: B2DA_DIGIT_W] =
            (r_bcd[g*B2DA_DIGIT_W +: B2DA_DIGIT_W] >= 4'd5) ?
            r_bcd[g*B2DA_DIGIT_W +: B2DA_DIGIT_W] + 4'd3 :
            r_bcd[g*B2DA_DIGIT_W +: B2DA_DIGIT_W];
    end

    assign w_top   = r_bcd[BCD_W-1 -: B2DA_DIGIT_W];
    assign w_final = (r_dig_cnt == DIG_CNT_W'(1));
    assign w_emit  = r_seen || (w_top != '0) || w_final;

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        n_seen    = r_seen;
        n_strobe  = 1'b0;
        n_ascii   = r_ascii;
        n_last    = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state   = ST_CONV;
                    n_bin     = i_value;
                    n_bcd     = '0;
                    n_bit_cnt = BIT_CNT_W'(VALUE_BITS - 1);
                end
            end
            ST_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = r_bin << 1;
                if (r_bit_cnt == '0) begin
                    n_state   = ST_EMIT;
                    n_dig_cnt = DIG_CNT_W'(NUM_DIGITS);
                    n_seen    = 1'b0;
                end else begin
                    n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
                end
            end
            ST_EMIT: begin
                n_bcd    = r_bcd << B2DA_DIGIT_W;
                n_seen   = w_emit;
                n_strobe = w_emit;
                n_ascii  = B2DA_ASCII_ZERO + {{(B2DA_ASCII_W-B2DA_DIGIT_W){1'b0}}, w_top};
                n_last   = w_final;
                if (w_final) begin
                    n_state = ST_IDLE;
                end else begin
                    n_dig_cnt = r_dig_cnt - DIG_CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_seen    <= n_seen;
        r_ascii   <= n_ascii;
        r_last    <= n_last;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_ascii_digit = r_ascii;
    assign o_last_digit  = r_last;

    `B2DA_ASSERT_NEXT(a_accept_conv, start && !busy, r_state == ST_CONV)
    `B2DA_ASSERT(a_strobe_from_emit, o_strobe |-> $past(r_state == ST_EMIT))
    `B2DA_ASSERT(a_digit_range, o_strobe |-> (o_ascii_digit >= 6'd48 && o_ascii_digit <= 6'd57))
    `B2DA_ASSERT(a_last_idle, (o_strobe && o_last_digit) |-> (r_state == ST_IDLE))

endmodule

// ===== bench/binary_to_decimal_ascii_digit_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digit_check
// watches the item and digit channels of the converter, works out the decimal
// digits of every accepted value and compares each strobed digit, code and
// end marker, with the oldest one still owed
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digit_check
    import b2da_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [31:0]             i_value,
    input  logic                    i_strobe,
    input  logic [B2DA_ASCII_W-1:0] i_ascii_digit,
    input  logic                    i_last_digit,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [B2DA_ASCII_W-1:0] code;
        logic                    last;
    } t_ascii_digit;

    t_ascii_digit owed_digits[$];

    // digits of one value, most significant first, no leading zeros
    function automatic void push_decimal_digits(input logic [31:0] value);
        logic [31:0] rest;
        logic [3:0]  digs[10];
        int          count;
        t_ascii_digit d;
        rest  = value;
        count = 0;
        do begin
            digs[count] = 4'(rest % 32'd10);
            rest        = rest / 32'd10;
            count++;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            d.code = B2DA_ASCII_ZERO + B2DA_ASCII_W'(digs[k]);
            d.last = (k == 0);
            owed_digits.push_back(d);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_ascii_digit want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (owed_digits.size() == 0) begin
                    $display("%0t: extra digit: expected none, actual %0d/%0b",
                             $time, i_ascii_digit, i_last_digit);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = owed_digits.pop_front();
                    if (i_ascii_digit !== want.code || i_last_digit !== want.last) begin
                        $display("%0t: digit mismatch: expected %0d/%0b, actual %0d/%0b",
                                 $time, want.code, want.last, i_ascii_digit, i_last_digit);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                push_decimal_digits(i_value);
            end
        end
        o_pending <= owed_digits.size();
    end

endmodule

// ===== bench/binary_to_decimal_ascii_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_tb
// drives 32-bit values into the converter: directed extremes and digit-count
// boundaries first, then random values spread over every digit count, with
// random gaps between items; a separate digit checker verifies the output
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top_tb;
    import b2da_pkg::*;

    localparam int RANDOM_ITEMS = 195;
    localparam int QUIET_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 200000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [31:0]             i_value;
    logic                    o_strobe;
    logic [B2DA_ASCII_W-1:0] o_ascii_digit;
    logic                    o_last_digit;

    logic item_taken;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   gaps_on;

    binary_to_decimal_ascii_top #(
        .VALUE_BITS(32)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_ascii_digit(o_ascii_digit),
        .o_last_digit (o_last_digit)
    );

    binary_to_decimal_ascii_digit_check u_digit_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_strobe     (o_strobe),
        .i_ascii_digit(o_ascii_digit),
        .i_last_digit (o_last_digit),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial item_taken = 1'b0;
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && start && !busy;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // hold one item until the converter takes it
    task automatic send_value(input logic [31:0] v);
        start   <= 1'b1;
        i_value <= v;
        do @(negedge i_clk); while (!item_taken);
    endtask

    task automatic maybe_idle();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        p = 1;
        for (int j = 0; j < k; j++) p = p * 10;
        return p;
    endfunction

    function automatic logic [31:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        int              k;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                k  = $urandom_range(1, 10);
                lo = (k == 1) ? 0 : pow10(k - 1);
                hi = pow10(k) - 1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
            end
            2: begin
                k = $urandom_range(1, 9);
                return 32'(pow10(k) + $urandom_range(0, 2) - 1);
            end
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd909,
                     32'd1000, 32'd65535, 32'd99999, 32'd123456, 32'd9999999,
                     32'd10000000, 32'd999999999, 32'd1000000000, 32'd1234567890,
                     32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd4000000000, 32'd4294967294, 32'd4294967295, 32'd0};

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        gaps_on = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n]) begin
            send_value(directed[n]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 32 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) gaps_on = 1'b0;
            // let the converter drain completely once mid-run
            if (n == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            send_value(pick_value());
            maybe_idle();
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
